// ----- sv/bcd_pkg.sv -----
// bcd_pkg: types, widths and constants for the brightness/chroma distortion pipeline
// no dependencies; imported by the interfaces and every module
package bcd_pkg;

	typedef struct packed {
		logic [7:0]  pixel_blue;
		logic [7:0]  pixel_green;
		logic [7:0]  pixel_red;
		logic [15:0] weight_blue;
		logic [15:0] weight_green;
		logic [15:0] weight_red;
		logic [15:0] mean_blue;
		logic [15:0] mean_green;
		logic [15:0] mean_red;
		logic [15:0] spread_blue;
		logic [15:0] spread_green;
		logic [15:0] spread_red;
	} in_item_t;

	typedef struct packed {
		logic [15:0] brightness_distortion;
		logic [23:0] chroma_distortion;
		logic [31:0] brightness_denominator;
	} out_item_t;

	localparam int NCH = 3;

	// restoring divider: dividend bits, divisor bits
	localparam int DIV_NW = 41;
	localparam int DIV_DW = 32;

	// integer square root: root bits, radicand bits
	localparam int SQ_OW = 25;
	localparam int SQ_IW = 2 * SQ_OW;

	// front stages, divider, two square/sum stages, root, output register
	localparam int LAT = 4 + DIV_NW + 2 + SQ_OW + 1;

	localparam logic [15:0] BRIGHT_MAX = 16'hFFFF;
	localparam logic [23:0] CHROMA_MAX = 24'hFFFFFF;
	localparam logic [31:0] DENOM_MAX  = 32'hFFFFFFFF;
	localparam logic [31:0] DENOM_ONE  = 32'd256;

endpackage

// ----- sv/bcd_in_if.sv -----
// bcd_in_if: valid/ready channel carrying one input pixel item
// depends on bcd_pkg
interface bcd_in_if import bcd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/bcd_out_if.sv -----
// bcd_out_if: valid/ready channel carrying one result item
// depends on bcd_pkg
interface bcd_out_if import bcd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/brightness_chroma_distortion_top.sv -----
// brightness_chroma_distortion_top: per-pixel brightness, chroma distortion and denominator
// depends on bcd_pkg, bcd_in_if, bcd_out_if, bcd_div, bcd_sqrt
//
// One pixel item is taken every clock cycle while the pipeline is not stalled. Most of the
// pipeline depth (LAT in bcd_pkg) comes from the 41-stage restoring dividers (residual over
// spread and squared mean over squared spread, run side by side) and the 25-stage square
// root. A stall on the result channel freezes the whole pipeline; pixel.ready is low only
// while a finished result waits and is not being taken.
module brightness_chroma_distortion_top import bcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bcd_in_if.sink    pixel,
	bcd_out_if.source result
);

	logic           en;
	logic [LAT-1:0] vld_q;

	logic [7:0]  pix_in [NCH];
	logic [15:0] wt_in  [NCH];
	logic [15:0] mean_in[NCH];
	logic [15:0] spr_in [NCH];

	assign pix_in[0]  = pixel.data.pixel_blue;
	assign pix_in[1]  = pixel.data.pixel_green;
	assign pix_in[2]  = pixel.data.pixel_red;
	assign wt_in[0]   = pixel.data.weight_blue;
	assign wt_in[1]   = pixel.data.weight_green;
	assign wt_in[2]   = pixel.data.weight_red;
	assign mean_in[0] = pixel.data.mean_blue;
	assign mean_in[1] = pixel.data.mean_green;
	assign mean_in[2] = pixel.data.mean_red;
	assign spr_in[0]  = (pixel.data.spread_blue == '0) ? 16'd1 : pixel.data.spread_blue;
	assign spr_in[1]  = (pixel.data.spread_green == '0) ? 16'd1 : pixel.data.spread_green;
	assign spr_in[2]  = (pixel.data.spread_red == '0) ? 16'd1 : pixel.data.spread_red;

	assign en          = !(vld_q[LAT-1] && !result.ready);
	assign pixel.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pixel.valid};
		end
	end

	// stage 1: products
	logic [23:0] prod_s1 [NCH];
	logic [31:0] mm_s1   [NCH];
	logic [31:0] ss_s1   [NCH];
	logic [7:0]  pix_s1  [NCH];
	logic [15:0] mean_s1 [NCH];
	logic [15:0] spr_s1  [NCH];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCH; c++) begin
				prod_s1[c] <= 24'(pix_in[c]) * 24'(wt_in[c]);
				mm_s1[c]   <= 32'(mean_in[c]) * 32'(mean_in[c]);
				ss_s1[c]   <= 32'(spr_in[c]) * 32'(spr_in[c]);
				pix_s1[c]  <= pix_in[c];
				mean_s1[c] <= mean_in[c];
				spr_s1[c]  <= spr_in[c];
			end
		end
	end

	// stage 2: brightness distortion, denominator dividends
	logic [25:0]       psum;
	logic [15:0]       bd_s2;
	logic [DIV_NW-1:0] dnum_s2 [NCH];
	logic [DIV_DW-1:0] dden_s2 [NCH];
	logic [7:0]        pix_s2  [NCH];
	logic [15:0]       mean_s2 [NCH];
	logic [15:0]       spr_s2  [NCH];

	assign psum = 26'(prod_s1[0]) + 26'(prod_s1[1]) + 26'(prod_s1[2]) + 26'd8;

	always_ff @(posedge clk) begin
		if (en) begin
			bd_s2 <= (psum[25:20] != '0) ? BRIGHT_MAX : psum[19:4];
			for (int c = 0; c < NCH; c++) begin
				dnum_s2[c] <= DIV_NW'({mm_s1[c], 8'h00}) + DIV_NW'(ss_s1[c][31:1]);
				dden_s2[c] <= ss_s1[c];
				pix_s2[c]  <= pix_s1[c];
				mean_s2[c] <= mean_s1[c];
				spr_s2[c]  <= spr_s1[c];
			end
		end
	end

	// stage 3: distortion times mean
	logic [15:0]       bd_s3;
	logic [31:0]       bm_s3   [NCH];
	logic [DIV_NW-1:0] dnum_s3 [NCH];
	logic [DIV_DW-1:0] dden_s3 [NCH];
	logic [7:0]        pix_s3  [NCH];
	logic [15:0]       spr_s3  [NCH];

	always_ff @(posedge clk) begin
		if (en) begin
			bd_s3 <= bd_s2;
			for (int c = 0; c < NCH; c++) begin
				bm_s3[c]   <= 32'(bd_s2) * 32'(mean_s2[c]);
				dnum_s3[c] <= dnum_s2[c];
				dden_s3[c] <= dden_s2[c];
				pix_s3[c]  <= pix_s2[c];
				spr_s3[c]  <= spr_s2[c];
			end
		end
	end

	// stage 4: residual magnitude plus half spread
	logic [15:0]       bd_s4;
	logic [32:0]       rnum_s4 [NCH];
	logic [DIV_NW-1:0] dnum_s4 [NCH];
	logic [DIV_DW-1:0] dden_s4 [NCH];
	logic [15:0]       spr_s4  [NCH];
	logic [31:0]       p16     [NCH];
	logic [31:0]       mag     [NCH];

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			p16[c] = 32'({pix_s3[c], 16'h0000});
			mag[c] = (p16[c] >= bm_s3[c]) ? (p16[c] - bm_s3[c]) : (bm_s3[c] - p16[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bd_s4 <= bd_s3;
			for (int c = 0; c < NCH; c++) begin
				rnum_s4[c] <= 33'(mag[c]) + 33'(spr_s3[c][15:1]);
				dnum_s4[c] <= dnum_s3[c];
				dden_s4[c] <= dden_s3[c];
				spr_s4[c]  <= spr_s3[c];
			end
		end
	end

	// dividers
	logic [DIV_NW-1:0] rq [NCH];
	logic [DIV_NW-1:0] dq [NCH];

	for (genvar c = 0; c < NCH; c++) begin : g_div
		bcd_div u_rdiv (
			.clk (clk),
			.en  (en),
			.num (DIV_NW'(rnum_s4[c])),
			.den (DIV_DW'(spr_s4[c])),
			.quo (rq[c])
		);
		bcd_div u_ddiv (
			.clk (clk),
			.en  (en),
			.num (dnum_s4[c]),
			.den (dden_s4[c]),
			.quo (dq[c])
		);
	end

	logic [15:0] bd_dly_q [DIV_NW];

	always_ff @(posedge clk) begin
		if (en) begin
			bd_dly_q[0] <= bd_s4;
			for (int i = 1; i < DIV_NW; i++) begin
				bd_dly_q[i] <= bd_dly_q[i-1];
			end
		end
	end

	// square residual quotients, finish denominator
	logic [47:0]       q2_s46 [NCH];
	logic              sat_s46;
	logic [31:0]       den_s46;
	logic [15:0]       bd_s46;
	logic [DIV_NW+1:0] dsum;
	logic              qbig;

	assign dsum = (DIV_NW+2)'(dq[0]) + (DIV_NW+2)'(dq[1]) + (DIV_NW+2)'(dq[2]);
	assign qbig = (rq[0] > DIV_NW'(CHROMA_MAX)) || (rq[1] > DIV_NW'(CHROMA_MAX))
		|| (rq[2] > DIV_NW'(CHROMA_MAX));

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s46 <= qbig;
			bd_s46  <= bd_dly_q[DIV_NW-1];
			if (dsum > (DIV_NW+2)'(DENOM_MAX)) begin
				den_s46 <= DENOM_MAX;
			end else if (dsum == '0) begin
				den_s46 <= DENOM_ONE;
			end else begin
				den_s46 <= dsum[31:0];
			end
			for (int c = 0; c < NCH; c++) begin
				q2_s46[c] <= 48'(rq[c][23:0]) * 48'(rq[c][23:0]);
			end
		end
	end

	// sum of squares
	logic [SQ_IW-1:0] sq_s47;
	logic             sat_s47;
	logic [31:0]      den_s47;
	logic [15:0]      bd_s47;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s47  <= SQ_IW'(q2_s46[0]) + SQ_IW'(q2_s46[1]) + SQ_IW'(q2_s46[2]);
			sat_s47 <= sat_s46;
			den_s47 <= den_s46;
			bd_s47  <= bd_s46;
		end
	end

	logic [SQ_OW-1:0] root;

	bcd_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.val  (sq_s47),
		.root (root)
	);

	logic        sat_dly_q [SQ_OW];
	logic [31:0] den_dly_q [SQ_OW];
	logic [15:0] bd2_dly_q [SQ_OW];

	always_ff @(posedge clk) begin
		if (en) begin
			sat_dly_q[0] <= sat_s47;
			den_dly_q[0] <= den_s47;
			bd2_dly_q[0] <= bd_s47;
			for (int i = 1; i < SQ_OW; i++) begin
				sat_dly_q[i] <= sat_dly_q[i-1];
				den_dly_q[i] <= den_dly_q[i-1];
				bd2_dly_q[i] <= bd2_dly_q[i-1];
			end
		end
	end

	// output register
	out_item_t res_q;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.brightness_distortion  <= bd2_dly_q[SQ_OW-1];
			res_q.brightness_denominator <= den_dly_q[SQ_OW-1];
			if (sat_dly_q[SQ_OW-1] || (root > SQ_OW'(CHROMA_MAX))) begin
				res_q.chroma_distortion <= CHROMA_MAX;
			end else begin
				res_q.chroma_distortion <= root[23:0];
			end
		end
	end

	assign result.valid = vld_q[LAT-1];
	assign result.data  = res_q;

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.ready == !(result.valid && !result.ready))
		else $error("input ready does not follow output stall");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during stall");

	a_denom_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.brightness_denominator != '0)
		else $error("zero brightness denominator delivered");

	a_sat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && sat_dly_q[SQ_OW-1]) |=> res_q.chroma_distortion == CHROMA_MAX)
		else $error("saturated residual not carried to chroma output");

endmodule

// ----- sv/bcd_div.sv -----
// bcd_div: pipelined restoring divider, one quotient bit per stage
// depends on bcd_pkg
module bcd_div import bcd_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_DW-1:0] rem_s [DIV_NW];
	logic [DIV_NW-1:0] num_s [DIV_NW];
	logic [DIV_DW-1:0] den_s [DIV_NW];
	logic [DIV_NW-1:0] quo_s [DIV_NW];

	for (genvar i = 0; i < DIV_NW; i++) begin : g_stage
		logic [DIV_DW-1:0] rem_in;
		logic [DIV_NW-1:0] num_in;
		logic [DIV_DW-1:0] den_in;
		logic [DIV_NW-1:0] quo_in;
		logic [DIV_DW:0]   sh;
		logic              ge;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign num_in = num_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign sh = {rem_in, num_in[DIV_NW-1]};
		assign ge = (sh >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DIV_DW'(sh - {1'b0, den_in}) : sh[DIV_DW-1:0];
				num_s[i] <= {num_in[DIV_NW-2:0], 1'b0};
				den_s[i] <= den_in;
				quo_s[i] <= {quo_in[DIV_NW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[DIV_NW-1];

endmodule

// ----- sv/bcd_sqrt.sv -----
// bcd_sqrt: pipelined floor integer square root, one root bit per stage
// depends on bcd_pkg
module bcd_sqrt import bcd_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SQ_IW-1:0] val,
	output logic [SQ_OW-1:0] root
);

	logic [SQ_OW:0]   rem_s  [SQ_OW];
	logic [SQ_OW-1:0] root_s [SQ_OW];
	logic [SQ_IW-1:0] val_s  [SQ_OW];

	for (genvar i = 0; i < SQ_OW; i++) begin : g_stage
		logic [SQ_OW:0]   rem_in;
		logic [SQ_OW-1:0] root_in;
		logic [SQ_IW-1:0] val_in;
		logic [SQ_OW+2:0] sh;
		logic [SQ_OW+2:0] trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign val_in  = val;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign val_in  = val_s[i-1];
		end

		assign sh    = {rem_in, val_in[SQ_IW-1:SQ_IW-2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge    = (sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (SQ_OW+1)'(sh - trial) : sh[SQ_OW:0];
				root_s[i] <= {root_in[SQ_OW-2:0], ge};
				val_s[i]  <= {val_in[SQ_IW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SQ_OW-1];

endmodule
